FILE: hw/rtl/recent_distinct_id_window_assert.svh
// Assertion macros used by the checker file of the identifier window.
`ifndef RECENT_DISTINCT_ID_WINDOW_ASSERT_SVH
`define RECENT_DISTINCT_ID_WINDOW_ASSERT_SVH

// Checked on every clock edge outside reset.
`define RDIW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("recent_distinct_id_window: assertion failed");

// Checked on every clock edge, during reset as well.
`define RDIW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("recent_distinct_id_window: assertion failed during reset");

`endif

FILE: hw/rtl/rdiw_pkg.sv
// Shared types and constants of the recent distinct identifier window.
`default_nettype none

package rdiw_pkg;

  // Field widths.
  localparam int unsigned IdW  = 32;
  localparam int unsigned CapW = 5;

  // Capacity after reset.
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Request opcodes.
  localparam logic OpMessage = 1'b0;
  localparam logic OpReadout = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMsg  = 3'b010,
    StRead = 3'b100
  } state_e;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // shift the chain one place older and load the new id at the head
    logic rotate;  // rotate the held entries one place towards the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rdiw_cell.sv
// One cell of the identifier chain: holds one entry and its valid bit.
`default_nettype none

module rdiw_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rdiw_pkg::cell_ctrl_t      ctrl_i,
  input  logic [rdiw_pkg::IdW-1:0]  cmp_id_i,
  input  logic                      keep_i,
  input  logic [rdiw_pkg::IdW-1:0]  prev_id_i,
  input  logic                      prev_vld_i,
  input  logic [rdiw_pkg::IdW-1:0]  next_id_i,
  input  logic                      next_vld_i,
  input  logic [rdiw_pkg::IdW-1:0]  head_id_i,
  output logic [rdiw_pkg::IdW-1:0]  id_o,
  output logic                      vld_o,
  output logic                      match_o
);

  logic [rdiw_pkg::IdW-1:0] id_q, id_d;
  logic                     vld_q, vld_d;

  // Insert takes the younger neighbour; rotate takes the older neighbour,
  // and the oldest held cell wraps round to the head entry.
  always_comb begin
    id_d  = id_q;
    vld_d = vld_q;
    if (ctrl_i.insert) begin
      id_d  = prev_id_i;
      vld_d = prev_vld_i & keep_i;
    end else if (ctrl_i.rotate) begin
      id_d = next_vld_i ? next_id_i : head_id_i;
    end
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // The identifier itself needs no reset.
  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o    = id_q;
  assign vld_o   = vld_q;
  assign match_o = vld_q && (id_q == cmp_id_i);

endmodule

`default_nettype wire

FILE: hw/rtl/recent_distinct_id_window.sv
// Top level of the recent distinct identifier window.
//
// Requests arrive on in_valid_i/in_ready_o with opcode_i and ident_i. A message
// request checks ident_i against every held entry in parallel and appends it
// when it is new, evicting the oldest entries down to capacity minus one first.
// It yields one result. A readout request yields the held identifiers newest
// first, one per cycle, with is_last_o on the final one, or a single result
// with window_empty_o when nothing is held.
// Steps: a message is accepted, then compared and applied to the chain. A readout
// is accepted, then shows its entries with the chain rotating one place per result
// shown. One request is worked on at a time; results sit in an output
// register, so a new request is accepted while the last result waits.
// When a result waits and out_ready_i is low, the controller holds and the chain
// stays put.
// Reset empties the window and sets the capacity to 16; the capacity register is
// written through cfg_we_i/cfg_wdata_i, by the user only while the block is idle (not enforced).
`default_nettype none

module recent_distinct_id_window #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write.
  input  logic                          cfg_we_i,
  input  logic [rdiw_pkg::CapW-1:0]     cfg_wdata_i,
  // Request channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [rdiw_pkg::IdW-1:0]      ident_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rdiw_pkg::IdW-1:0]      shown_id_o,
  output logic                          already_present_o,
  output logic                          window_empty_o,
  output logic                          is_last_o
);

  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > rdiw_pkg::CapW) ? CntW : rdiw_pkg::CapW;

  // Capacity register.
  logic [rdiw_pkg::CapW-1:0] capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= rdiw_pkg::CapReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Effective capacity, clamped to one up to the window depth.
  logic [CmpW-1:0] cap_raw;
  logic [CmpW-1:0] cap_eff;

  always_comb begin
    cap_raw = CmpW'(capacity_q);
    if (cap_raw == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_raw > CmpW'(WINDOW_DEPTH)) begin
      cap_eff = CmpW'(WINDOW_DEPTH);
    end else begin
      cap_eff = cap_raw;
    end
  end

  // Latched request identifier.
  logic [rdiw_pkg::IdW-1:0] id_q;

  // Controller state.
  rdiw_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  idx_q, idx_d;

  // Chain signals.
  rdiw_pkg::cell_ctrl_t     ctrl;
  logic [rdiw_pkg::IdW-1:0] cell_id  [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]  cell_vld;
  logic [WINDOW_DEPTH-1:0]  match;
  logic                     found;

  assign found = |match;

  // The chain of cells; cell 0 holds the newest entry.
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic [rdiw_pkg::IdW-1:0] prev_id;
    logic                     prev_vld;
    logic [rdiw_pkg::IdW-1:0] next_id;
    logic                     next_vld;
    logic                     keep;

    if (k == 0) begin : g_head
      assign prev_id  = id_q;
      assign prev_vld = 1'b1;
    end else begin : g_body
      assign prev_id  = cell_id[k-1];
      assign prev_vld = cell_vld[k-1];
    end

    if (k == WINDOW_DEPTH - 1) begin : g_tail
      assign next_id  = '0;
      assign next_vld = 1'b0;
    end else begin : g_inner
      assign next_id  = cell_id[k+1];
      assign next_vld = cell_vld[k+1];
    end

    assign keep = CmpW'(k) < cap_eff;

    rdiw_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .cmp_id_i  (id_q),
      .keep_i    (keep),
      .prev_id_i (prev_id),
      .prev_vld_i(prev_vld),
      .next_id_i (next_id),
      .next_vld_i(next_vld),
      .head_id_i (cell_id[0]),
      .id_o      (cell_id[k]),
      .vld_o     (cell_vld[k]),
      .match_o   (match[k])
    );
  end

  // Output register slot.
  logic                     out_valid_q;
  logic [rdiw_pkg::IdW-1:0] shown_id_q;
  logic                     present_q;
  logic                     empty_q;
  logic                     last_q;
  logic                     out_free;
  logic                     emit;
  logic [rdiw_pkg::IdW-1:0] emit_id;
  logic                     emit_present;
  logic                     emit_empty;
  logic                     emit_last;
  logic                     in_accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == rdiw_pkg::StIdle);
  assign in_accept  = in_valid_i && in_ready_o;

  // Controller: one request at a time, stepping only when the output slot is free.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    ctrl         = '0;
    emit         = 1'b0;
    emit_id      = '0;
    emit_present = 1'b0;
    emit_empty   = 1'b0;
    emit_last    = 1'b0;
    unique case (state_q)
      rdiw_pkg::StIdle: begin
        if (in_accept) begin
          idx_d   = '0;
          state_d = (opcode_i == rdiw_pkg::OpMessage) ? rdiw_pkg::StMsg : rdiw_pkg::StRead;
        end
      end
      rdiw_pkg::StMsg: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_present = found;
          emit_last    = 1'b1;
          if (!found) begin
            ctrl.insert = 1'b1;
            if (CmpW'(cnt_q) >= cap_eff) begin
              cnt_d = CntW'(cap_eff);
            end else begin
              cnt_d = cnt_q + CntW'(1);
            end
          end
          state_d = rdiw_pkg::StIdle;
        end
      end
      rdiw_pkg::StRead: begin
        if (out_free) begin
          emit = 1'b1;
          if (cnt_q == '0) begin
            emit_empty = 1'b1;
            emit_last  = 1'b1;
            state_d    = rdiw_pkg::StIdle;
          end else begin
            emit_id     = cell_id[0];
            emit_last   = (idx_q + CntW'(1)) == cnt_q;
            ctrl.rotate = 1'b1;
            idx_d       = idx_q + CntW'(1);
            if (emit_last) begin
              state_d = rdiw_pkg::StIdle;
            end
          end
        end
      end
      default: begin
        state_d = rdiw_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdiw_pkg::StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      id_q <= ident_i;
    end
    if (emit) begin
      shown_id_q <= emit_id;
      present_q  <= emit_present;
      empty_q    <= emit_empty;
      last_q     <= emit_last;
    end
  end

  // Result ports come straight from the output register.
  assign out_valid_o       = out_valid_q;
  assign shown_id_o        = shown_id_q;
  assign already_present_o = present_q;
  assign window_empty_o    = empty_q;
  assign is_last_o         = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rdiw_checker.sv
// Port-level checker for the recent distinct identifier window, bound to the top level.
`default_nettype none

`include "recent_distinct_id_window_assert.svh"

module rdiw_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_o,
  input  logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic [rdiw_pkg::IdW-1:0] shown_id_o,
  input  logic                     already_present_o,
  input  logic                     window_empty_o,
  input  logic                     is_last_o
);

  // A pending result is held until it is taken.
  `RDIW_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // A message result that finds its identifier present carries no identifier and closes its request.
  `RDIW_ASSERT(a_present_fmt, out_valid_o && already_present_o |-> is_last_o && !window_empty_o && (shown_id_o == '0))

  // An empty readout is a single result with nothing else set.
  `RDIW_ASSERT(a_empty_fmt, out_valid_o && window_empty_o |-> is_last_o && !already_present_o && (shown_id_o == '0))

  // A request is worked on alone: no second request right after one is accepted.
  `RDIW_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o)

  // No result is shown while reset is applied.
  `RDIW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o)

endmodule

bind recent_distinct_id_window rdiw_checker u_rdiw_checker (.*);

`default_nettype wire
